>>> sv/multiple_recursive_generator_unit_assert.svh
// Assertion macros shared by the generator modules.
`ifndef MULTIPLE_RECURSIVE_GENERATOR_UNIT_ASSERT_SVH
`define MULTIPLE_RECURSIVE_GENERATOR_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define MRG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MRG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/mrg_pkg.sv
// Shared constants, register codes and types of the recursive generator.
`timescale 1ns / 1ps

package mrg_pkg;

    localparam int ORDER_DEFAULT      = 4;
    localparam int VALUE_BITS_DEFAULT = 31;

    // Number of coefficient registers.
    localparam int NUM_COEFS = 4;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_USED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_4     = 3'd5;

    localparam int ORDER_USED_W = 3;

    localparam logic [31:0] MODULUS_RESET = 32'h7FFF_FFFF;
    localparam logic [ORDER_USED_W-1:0] ORDER_USED_RESET = 3'd1;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

endpackage

>>> sv/mrg_if.sv
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface mrg_item_if #(
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [VALUE_BITS-1:0] seed_value;

    modport source (output valid, output command, output seed_value, input ready);
    modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface mrg_value_if #(
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mrg_cfg_if #(
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT
);
    logic                           valid;
    logic                           ready;
    logic [mrg_pkg::CFG_IDX_W-1:0]  index;
    logic [VALUE_BITS-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mrg_mac.sv
// Shared multiplier with a wide accumulator for the recursion terms.
`timescale 1ns / 1ps

module mrg_mac #(
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT,
    parameter int SUM_BITS   = 2 * VALUE_BITS + 2
) (
    input  logic                  i_clk,
    input  mrg_pkg::t_mac_ctrl    i_ctrl,
    input  logic [VALUE_BITS-1:0] i_coef,
    input  logic [VALUE_BITS-1:0] i_hist,
    output logic [SUM_BITS-1:0]   o_acc
);

    localparam int PROD_BITS = 2 * VALUE_BITS;

    logic [PROD_BITS-1:0] r_prod;
    logic [SUM_BITS-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PROD_BITS'(i_coef) * PROD_BITS'(i_hist);
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + SUM_BITS'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

>>> sv/mrg_rem.sv
// Radix-4 restoring remainder unit: two dividend bits per cycle.
`timescale 1ns / 1ps

`include "multiple_recursive_generator_unit_assert.svh"

module mrg_rem #(
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT,
    parameter int SUM_BITS   = 2 * VALUE_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_BITS-1:0]   i_dividend,
    input  logic [VALUE_BITS-1:0] i_modulus,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_rem
);

    localparam int STEPS  = SUM_BITS / 2;
    localparam int CNT_W  = $clog2(STEPS);
    localparam int WIDE   = VALUE_BITS + 2;
    localparam int DIFF_W = VALUE_BITS + 3;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SUM_BITS-1:0]   r_dividend;
    logic [VALUE_BITS-1:0] r_rem;

    logic [WIDE-1:0]       shifted;
    logic [WIDE-1:0]       m1;
    logic [WIDE-1:0]       m2;
    logic [WIDE-1:0]       m3;
    logic [DIFF_W-1:0]     d1;
    logic [DIFF_W-1:0]     d2;
    logic [DIFF_W-1:0]     d3;
    logic [VALUE_BITS-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dividend[SUM_BITS-1 -: 2]};
        m1      = WIDE'(i_modulus);
        m2      = {1'b0, i_modulus, 1'b0};
        m3      = m1 + m2;
        d1      = DIFF_W'(shifted) - DIFF_W'(m1);
        d2      = DIFF_W'(shifted) - DIFF_W'(m2);
        d3      = DIFF_W'(shifted) - DIFF_W'(m3);
        // Take the largest multiple of the modulus that still fits.
        priority if (!d3[DIFF_W-1]) begin
            n_rem = d3[VALUE_BITS-1:0];
        end else if (!d2[DIFF_W-1]) begin
            n_rem = d2[VALUE_BITS-1:0];
        end else if (!d1[DIFF_W-1]) begin
            n_rem = d1[VALUE_BITS-1:0];
        end else begin
            n_rem = shifted[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= {r_dividend[SUM_BITS-3:0], 2'b00};
            r_rem      <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `MRG_ASSERT(a_start_busy, i_start |=> (r_busy && r_cnt == '0), "remainder unit did not start")
    `MRG_ASSERT_ALWAYS(a_done_idle, r_done |-> !r_busy, "remainder done while still busy")
    `MRG_ASSERT(a_last_step, (r_busy && !i_start && r_cnt == CNT_W'(STEPS - 1)) |=> r_done,
        "remainder unit missed its last step")

endmodule

>>> sv/multiple_recursive_generator_unit.sv
// Top level of the recursive generator: registers, history and sequencer.
// A load-seed item gives no result; the next item may follow at once.
// A generate item runs a multiply and an accumulate step for each of the k terms in use,
// then the load state, SUM_BITS/2 = 32 remainder steps and the done state.
// The next item is taken as the done state ends, later while a result waits.
// Synchronous active-low reset clears history, control state and registers to defaults.
`timescale 1ns / 1ps

`include "multiple_recursive_generator_unit_assert.svh"

module multiple_recursive_generator_unit #(
    parameter int ORDER      = mrg_pkg::ORDER_DEFAULT,
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrg_item_if.sink    i_item,
    mrg_cfg_if.sink     i_cfg,
    mrg_value_if.source o_result
);

    localparam int SUM_BITS = 2 * VALUE_BITS + 2;
    localparam int NTERM    = (ORDER < mrg_pkg::NUM_COEFS) ? ORDER : mrg_pkg::NUM_COEFS;
    localparam int CNT_W    = $clog2(NTERM + 1);
    localparam int OU_W     = mrg_pkg::ORDER_USED_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_REM  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [CNT_W-1:0]      r_term;
    logic [VALUE_BITS-1:0] r_modulus;
    logic [OU_W-1:0]       r_order_used;
    logic [VALUE_BITS-1:0] r_coef [mrg_pkg::NUM_COEFS];
    logic [VALUE_BITS-1:0] r_hist [ORDER];
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;

    logic [CNT_W-1:0]      k_use;
    logic [VALUE_BITS-1:0] coef_sel;
    logic [VALUE_BITS-1:0] hist_sel;
    mrg_pkg::t_mac_ctrl    mac_ctrl;
    logic [SUM_BITS-1:0]   acc;
    logic                  rem_start;
    logic                  rem_done;
    logic [VALUE_BITS-1:0] rem;
    logic                  in_fire;
    logic                  out_free;
    logic                  push;
    logic [VALUE_BITS-1:0] push_value;

    assign k_use = (r_order_used > OU_W'(NTERM)) ? CNT_W'(NTERM) : CNT_W'(r_order_used);

    always_comb begin
        coef_sel = '0;
        hist_sel = '0;
        for (int i = 0; i < NTERM; i++) begin
            if (r_term == CNT_W'(i)) begin
                coef_sel = r_coef[i];
                hist_sel = r_hist[i];
            end
        end
    end

    assign i_item.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_fire      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;

    always_comb begin
        n_state         = r_state;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        rem_start       = 1'b0;
        push            = 1'b0;
        push_value      = rem;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_item.command) begin
                        mac_ctrl.clear = 1'b1;
                        n_state = (k_use == '0) ? ST_LOAD : ST_MUL;
                    end else begin
                        push       = 1'b1;
                        push_value = i_item.seed_value;
                    end
                end
            end
            ST_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                mac_ctrl.acc_en = 1'b1;
                n_state = (r_term + 1'b1 == k_use) ? ST_LOAD : ST_MUL;
            end
            ST_LOAD: begin
                rem_start = 1'b1;
                n_state = ST_REM;
            end
            ST_REM: begin
                if (rem_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    push = 1'b1;
                    // With a zero modulus no reduction exists and the value is zero.
                    push_value = (r_modulus == '0) ? '0 : rem;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ORDER; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (mac_ctrl.clear) begin
                r_term <= '0;
            end else if (mac_ctrl.acc_en) begin
                r_term <= r_term + 1'b1;
            end
            if (push) begin
                for (int i = ORDER - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= push_value;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_value <= push_value;
        end
    end

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= VALUE_BITS'(mrg_pkg::MODULUS_RESET);
            r_order_used <= mrg_pkg::ORDER_USED_RESET;
            r_coef[0]    <= VALUE_BITS'(1);
            for (int i = 1; i < mrg_pkg::NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mrg_pkg::CFG_MODULUS:    r_modulus    <= i_cfg.data;
                mrg_pkg::CFG_ORDER_USED: r_order_used <= i_cfg.data[OU_W-1:0];
                mrg_pkg::CFG_COEF_1:     r_coef[0]    <= i_cfg.data;
                mrg_pkg::CFG_COEF_2:     r_coef[1]    <= i_cfg.data;
                mrg_pkg::CFG_COEF_3:     r_coef[2]    <= i_cfg.data;
                mrg_pkg::CFG_COEF_4:     r_coef[3]    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.value = r_out_value;

    mrg_mac #(
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_coef (coef_sel),
        .i_hist (hist_sel),
        .o_acc  (acc)
    );

    mrg_rem #(
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (acc),
        .i_modulus  (r_modulus),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    `MRG_ASSERT(a_term_range, (r_state == ST_MUL) |-> (r_term < k_use),
        "term index beyond the terms in use")
    `MRG_ASSERT(a_rem_to_done, (r_state == ST_REM && rem_done) |=> (r_state == ST_DONE),
        "remainder result not taken")
    `MRG_ASSERT(a_result_shown, (r_state == ST_DONE && out_free) |=> r_out_valid,
        "finished item did not reach the output register")

endmodule

>>> verif/mrg_checker.sv
// Checker for the recursive generator: tracks its state, predicts and compares each result.
`timescale 1ns / 1ps

module mrg_checker #(
    parameter int ORDER      = mrg_pkg::ORDER_DEFAULT,
    parameter int VALUE_BITS = mrg_pkg::VALUE_BITS_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mrg_item_if   item_bus,
    mrg_cfg_if    cfg_bus,
    mrg_value_if  result_bus,
    output int    o_fail_count,
    output int    o_pending
);
    import mrg_pkg::*;

    typedef logic [VALUE_BITS-1:0] value_t;

    value_t                  modulus_q;
    logic [ORDER_USED_W-1:0] order_q;
    value_t                  coef_q [NUM_COEFS];
    value_t                  history_q [ORDER];
    value_t                  expected_values [$];
    int                      fail_count = 0;
    int                      pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Products and partial sums are reduced one term at a time, which keeps
    // every intermediate below 2^62.
    function automatic value_t next_value();
        logic [63:0] acc;
        logic [63:0] prod;
        int          terms;
        acc = '0;
        if (modulus_q != '0) begin
            terms = int'(order_q);
            if (terms > ORDER)
                terms = ORDER;
            if (terms > NUM_COEFS)
                terms = NUM_COEFS;
            for (int j = 0; j < terms; j++) begin
                prod = (64'(coef_q[j]) * 64'(history_q[j])) % 64'(modulus_q);
                acc  = (acc + prod) % 64'(modulus_q);
            end
        end
        return value_t'(acc);
    endfunction

    task automatic shift_history(input value_t v);
        for (int i = ORDER - 1; i > 0; i--)
            history_q[i] = history_q[i-1];
        history_q[0] = v;
    endtask

    always @(posedge i_clk) begin : track
        value_t predicted;
        value_t wanted;
        if (!i_rst_n) begin
            modulus_q = value_t'(MODULUS_RESET);
            order_q   = ORDER_USED_RESET;
            coef_q[0] = value_t'(1);
            for (int j = 1; j < NUM_COEFS; j++)
                coef_q[j] = '0;
            for (int i = 0; i < ORDER; i++)
                history_q[i] = '0;
            expected_values.delete();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_MODULUS:    modulus_q = cfg_bus.data;
                    CFG_ORDER_USED: order_q   = cfg_bus.data[ORDER_USED_W-1:0];
                    CFG_COEF_1:     coef_q[0] = cfg_bus.data;
                    CFG_COEF_2:     coef_q[1] = cfg_bus.data;
                    CFG_COEF_3:     coef_q[2] = cfg_bus.data;
                    CFG_COEF_4:     coef_q[3] = cfg_bus.data;
                    default: ;
                endcase
            end
            if (result_bus.valid && result_bus.ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d",
                                              result_bus.value));
                end else begin
                    wanted = expected_values.pop_front();
                    if (result_bus.value !== wanted)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  result_bus.value, wanted));
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                if (item_bus.command) begin
                    predicted = next_value();
                    expected_values.push_back(predicted);
                    shift_history(predicted);
                end else begin
                    // Seeds go in as given, even when not below the modulus.
                    shift_history(item_bus.seed_value);
                end
            end
        end
        pending = expected_values.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the generator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import mrg_pkg::*;

    localparam int ORDER        = ORDER_DEFAULT;
    localparam int VALUE_BITS   = VALUE_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 500;

    typedef logic [VALUE_BITS-1:0] value_t;

    localparam value_t VALUE_MAX = '1;
    localparam value_t COEF_MAX  = VALUE_MAX - 1;
    localparam value_t MOD_MAX   = value_t'(MODULUS_RESET);

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_COEF_4 + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     fail_count;
    int     pending;
    int     send_idle_pct = 0;
    int     rx_stall_pct = 0;
    logic   rx_hold_req = 1'b0;
    int     cycle_count = 0;
    value_t cur_modulus = MOD_MAX;

    mrg_item_if  #(.VALUE_BITS(VALUE_BITS)) item_bus ();
    mrg_cfg_if   #(.VALUE_BITS(VALUE_BITS)) cfg_bus ();
    mrg_value_if #(.VALUE_BITS(VALUE_BITS)) result_bus ();

    multiple_recursive_generator_unit #(
        .ORDER      (ORDER),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    mrg_checker #(
        .ORDER      (ORDER),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_bus     (item_bus),
        .cfg_bus      (cfg_bus),
        .result_bus   (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side: a requested hold-off is counted down here, otherwise random stalls.
    initial begin : rx_side
        int hold_left;
        bit hold_taken;
        hold_left        = 0;
        hold_taken       = 1'b0;
        result_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                result_bus.ready = 1'b0;
                hold_left--;
            end else begin
                result_bus.ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Leaves valid high after acceptance so back-to-back items need no gap.
    task automatic send_item(input logic cmd, input value_t seed);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid      = 1'b1;
        item_bus.command    = cmd;
        item_bus.seed_value = seed;
        @(posedge i_clk);
        while (!item_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input value_t data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
        if (idx == CFG_MODULUS)
            cur_modulus = data;
    endtask

    // A seed load gives no result, so the drain covers one that may still be in work.
    task automatic wait_idle();
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_generator(input value_t modulus, input value_t order,
                                 input value_t c1, input value_t c2,
                                 input value_t c3, input value_t c4);
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_ORDER_USED, order);
        write_reg(CFG_COEF_1, c1);
        write_reg(CFG_COEF_2, c2);
        write_reg(CFG_COEF_3, c3);
        write_reg(CFG_COEF_4, c4);
    endtask

    function automatic value_t pick_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return VALUE_MAX;
            2:       return COEF_MAX;
            3:       return value_t'($urandom_range(16));
            default: return value_t'($urandom());
        endcase
    endfunction

    function automatic value_t pick_seed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VALUE_MAX;
            2, 3:    return value_t'($urandom());
            default: return (cur_modulus == '0) ? value_t'($urandom())
                                                : value_t'($urandom()) % cur_modulus;
        endcase
    endfunction

    task automatic random_settings();
        value_t modulus;
        value_t order;
        case ($urandom_range(11))
            0:       modulus = MOD_MAX;
            1:       modulus = value_t'(2);
            2:       modulus = MOD_MAX - 1;
            3:       modulus = value_t'($urandom_range(1000, 2));
            4:       modulus = value_t'($urandom_range(1));
            default: modulus = value_t'($urandom());
        endcase
        order = ($urandom_range(1) == 0) ? value_t'($urandom_range(4, 1))
                                         : value_t'($urandom_range(7));
        // Bits above the order field are ignored by the block.
        if ($urandom_range(3) == 0)
            order = (value_t'($urandom()) & ~value_t'(7)) | order;
        set_generator(modulus, order, pick_coef(), pick_coef(), pick_coef(), pick_coef());
    endtask

    initial begin
        item_bus.valid      = 1'b0;
        item_bus.command    = 1'b0;
        item_bus.seed_value = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_MODULUS;
        cfg_bus.data        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults: a seed equal to the modulus must come back as zero.
        send_item(1'b1, '0);
        send_item(1'b0, VALUE_MAX);
        send_item(1'b1, VALUE_MAX);
        send_item(1'b0, value_t'(12345));
        send_item(1'b1, '0);
        wait_idle();

        // Largest operands with all four terms.
        set_generator(MOD_MAX, value_t'(4), COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        repeat (4) send_item(1'b0, COEF_MAX);
        send_item(1'b1, VALUE_MAX);
        send_item(1'b1, '0);
        wait_idle();

        // No terms in use gives zero.
        write_reg(CFG_ORDER_USED, '0);
        send_item(1'b1, '0);
        wait_idle();
        // An order beyond the coefficient count is clipped to four terms.
        write_reg(CFG_ORDER_USED, VALUE_MAX);
        send_item(1'b1, '0);
        wait_idle();
        write_reg(CFG_MODULUS, '0);
        send_item(1'b1, '0);
        wait_idle();
        write_reg(CFG_MODULUS, value_t'(1));
        send_item(1'b1, '0);
        wait_idle();

        write_reg(CFG_SPARE_LO, VALUE_MAX);
        write_reg(CFG_SPARE_HI, VALUE_MAX);
        set_generator(value_t'(2), value_t'(2), value_t'(1), value_t'(1), '0, '0);
        send_item(1'b0, value_t'(1));
        send_item(1'b0, value_t'(1));
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin send_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            random_settings();
            // The block fills up behind a long hold-off while items keep coming.
            if (phase == 0)
                rx_hold_req = 1'b1;
            repeat (ORDER) send_item(1'b0, pick_seed());
            repeat (PHASE_ITEMS - ORDER) begin
                if ($urandom_range(99) < 25)
                    send_item(1'b0, pick_seed());
                else
                    send_item(1'b1, value_t'($urandom()));
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
